// File: rtl/core/pli_pkg.sv
// Shared types and constants for the piecewise linear interpolator.
`default_nettype none
package pli_pkg;
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_REQ,
      ST_SCAN,
      ST_INS_CHECK,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_WRITE,
      ST_Q_LATCH,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_RESULT
   } pli_state_type;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;
endpackage
`default_nettype wire

// File: rtl/core/pli_if.sv
// Valid/ready channel interface for request and response items.
`default_nettype none
interface pli_if #(
   parameter int PAYLOAD_WIDTH = 8
) ();
   logic                     valid;
   logic                     ready;
   logic [PAYLOAD_WIDTH-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/pli_muldiv.sv
// Bit-serial floor(a * b / d) unit, one bit of a per cycle, b < d.
`default_nettype none
module pli_muldiv #(
   parameter int W = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] a,
   input  wire logic [W-1:0] b,
   input  wire logic [W-1:0] d,
   output logic              done,
   output logic [W-1:0]      quotient
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  a_ff, a_in;
   logic [W-1:0]  b_ff, b_in;
   logic [W-1:0]  d_ff, d_in;
   logic [W-1:0]  r_ff, r_in;
   logic [W-1:0]  q_ff, q_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W-1:0]  r_dbl;
   logic          q_dbl;
   logic [W-1:0]  q_tmp;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      d_in    = d_ff;
      r_in    = r_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      // r stays below d; doubling and adding b use d - r and d - b to avoid overflow
      if (r_ff >= d_ff - r_ff) begin
         r_dbl = r_ff - (d_ff - r_ff);
         q_dbl = 1'b1;
      end else begin
         r_dbl = r_ff + r_ff;
         q_dbl = 1'b0;
      end
      q_tmp = {q_ff[W-2:0], q_dbl};
      if (start) begin
         a_in    = a;
         b_in    = b;
         d_in    = d;
         r_in    = '0;
         q_in    = '0;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (a_ff[W-1]) begin
            if (r_dbl >= d_ff - b_ff) begin
               r_in = r_dbl - (d_ff - b_ff);
               q_in = q_tmp + W'(1);
            end else begin
               r_in = r_dbl + b_ff;
               q_in = q_tmp;
            end
         end else begin
            r_in = r_dbl;
            q_in = q_tmp;
         end
         a_in   = {a_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      d_ff <= d_in;
      r_ff <= r_in;
      q_ff <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;
endmodule
`default_nettype wire

// File: rtl/core/pli_table.sv
// Breakpoint memory: x and y words in one synchronous RAM, one read and one write port.
`default_nettype none
module pli_table #(
   parameter int DEPTH = 64,
   parameter int W     = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [2*W-1:0]           wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [2*W-1:0]                rd_data
);
   logic [2*W-1:0] mem [DEPTH];
   logic [2*W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// File: rtl/core/piecewise_linear_interpolator.sv
// Top level of the piecewise linear interpolator.
// Usage:
//   req channel carries {func, first, x_in, y_in}; func 0 loads a breakpoint,
//   func 1 queries. Only a query yields an item on the rsp channel
//   {value, in_range}. Breakpoints stay sorted by x in one synchronous RAM.
//   Steps, W = VALUE_WIDTH, after the item is accepted in idle:
//     load : scan, a read request and a compare per entry, then shift
//            entries up one at a time, a read and a write per entry.
//     query: scan for the first x at or above the query, latch the lower
//            neighbor, bit-serial multiply-divide of W steps, hand-off to
//            the output register.
//   One item is in work at a time; req_ready is high only when idle.
//   The response sits in an output register, so a load can proceed while
//   rsp_ready is low; a query result waits in its last state until the
//   output register is free, and meanwhile no new item is taken.
//   Reset empties the table at once (point count to zero); RAM contents are
//   never cleared, entries are only read below the count.
`default_nettype none
module piecewise_linear_interpolator #(
   parameter int TABLE_DEPTH = 64,
   parameter int VALUE_WIDTH = 32
) (
   input wire logic clock,
   input wire logic reset,
   pli_if.sink      req,
   pli_if.source    rsp
);
   localparam int W  = VALUE_WIDTH;
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic          req_func, req_first;
   logic [W-1:0]  req_x, req_y;

   assign req_func  = req.data[2*W+1];
   assign req_first = req.data[2*W];
   assign req_x     = req.data[2*W-1:W];
   assign req_y     = req.data[W-1:0];

   pli_pkg::pli_state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] shift_pos_ff, shift_pos_in;
   logic          func_ff, func_in;
   logic [W-1:0]  x_ff, x_in;
   logic [W-1:0]  y_ff, y_in;
   logic [W-1:0]  x0_ff, x0_in, y0_ff, y0_in;
   logic [W-1:0]  x1_ff, x1_in, y1_ff, y1_in;
   logic          up_ff, up_in;
   logic          hit_ff, hit_in;
   logic [W-1:0]  value_ff, value_in;
   logic          inr_ff, inr_in;
   logic [W-1:0]  out_value_ff, out_value_in;
   logic          out_inr_ff, out_inr_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [2*W-1:0] wr_data, rd_data;
   logic [W-1:0]  rd_x, rd_y;
   logic          md_start, md_done;
   logic [W-1:0]  md_q;
   logic [W-1:0]  mag, span, dx;

   assign rd_x = rd_data[2*W-1:W];
   assign rd_y = rd_data[W-1:0];

   pli_table #(.DEPTH(TABLE_DEPTH), .W(W)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign mag  = up_ff ? (y1_ff - y0_ff) : (y0_ff - y1_ff);
   assign span = x1_ff - x0_ff;
   assign dx   = x_ff - x0_ff;

   pli_muldiv #(.W(W)) u_muldiv (
      .clock    (clock),
      .reset    (reset),
      .start    (md_start),
      .a        (mag),
      .b        (dx),
      .d        (span),
      .done     (md_done),
      .quotient (md_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pli_pkg::ST_IDLE: begin
            if (req.valid) begin
               state_in = pli_pkg::ST_SCAN_REQ;
            end
         end
         pli_pkg::ST_SCAN_REQ: begin
            if (idx_ff == count_ff) begin
               state_in = (func_ff == pli_pkg::FUNC_LOAD) ? pli_pkg::ST_INS_CHECK
                                                        : pli_pkg::ST_RESULT;
            end else begin
               state_in = pli_pkg::ST_SCAN;
            end
         end
         pli_pkg::ST_SCAN: begin
            if ($signed(rd_x) >= $signed(x_ff)) begin
               if (func_ff == pli_pkg::FUNC_LOAD) begin
                  state_in = pli_pkg::ST_INS_CHECK;
               end else if (rd_x == x_ff || idx_ff == CW'(0)) begin
                  state_in = pli_pkg::ST_RESULT;
               end else begin
                  state_in = pli_pkg::ST_Q_LATCH;
               end
            end else begin
               state_in = pli_pkg::ST_SCAN_REQ;
            end
         end
         pli_pkg::ST_INS_CHECK: begin
            if (hit_ff || count_ff == CW'(TABLE_DEPTH)) begin
               state_in = pli_pkg::ST_IDLE;
            end else if (count_ff == idx_ff) begin
               state_in = pli_pkg::ST_WRITE;
            end else begin
               state_in = pli_pkg::ST_SHIFT_RD;
            end
         end
         pli_pkg::ST_SHIFT_RD: state_in = pli_pkg::ST_SHIFT_WR;
         pli_pkg::ST_SHIFT_WR: begin
            // shifting walks down from count to idx
            if (shift_pos_ff == idx_ff + CW'(1)) begin
               state_in = pli_pkg::ST_WRITE;
            end else begin
               state_in = pli_pkg::ST_SHIFT_RD;
            end
         end
         pli_pkg::ST_WRITE: state_in = pli_pkg::ST_IDLE;
         pli_pkg::ST_Q_LATCH: state_in = pli_pkg::ST_DIV_GO;
         pli_pkg::ST_DIV_GO: state_in = pli_pkg::ST_DIV_WAIT;
         pli_pkg::ST_DIV_WAIT: begin
            if (md_done) begin
               state_in = pli_pkg::ST_RESULT;
            end
         end
         pli_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               state_in = pli_pkg::ST_IDLE;
            end
         end
         default: state_in = pli_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      func_in      = func_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      x0_in        = x0_ff;
      y0_in        = y0_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      up_in        = up_ff;
      hit_in       = hit_ff;
      value_in     = value_ff;
      inr_in       = inr_ff;
      out_value_in = out_value_ff;
      out_inr_in   = out_inr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      shift_pos_in = shift_pos_ff;
      req.ready    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = AW'(idx_ff);
      wr_data      = {x_ff, y_ff};
      rd_addr      = AW'(idx_ff);
      md_start     = 1'b0;
      case (state_ff)
         pli_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               func_in  = req_func;
               x_in     = req_x;
               y_in     = req_y;
               idx_in   = '0;
               hit_in   = 1'b0;
               value_in = '0;
               inr_in   = 1'b0;
               if (req_func == pli_pkg::FUNC_LOAD && req_first) begin
                  count_in = '0;
               end
            end
         end
         pli_pkg::ST_SCAN_REQ: begin
            rd_addr = AW'(idx_ff);
         end
         pli_pkg::ST_SCAN: begin
            if ($signed(rd_x) >= $signed(x_ff)) begin
               hit_in = (rd_x == x_ff);
               x1_in  = rd_x;
               y1_in  = rd_y;
               if (func_ff == pli_pkg::FUNC_QUERY && rd_x == x_ff) begin
                  value_in = rd_y;
                  inr_in   = 1'b1;
               end
            end else begin
               idx_in = idx_ff + CW'(1);
            end
            // lower neighbor, used only when the query lands between two points
            rd_addr = (idx_ff == CW'(0)) ? '0 : AW'(idx_ff - CW'(1));
         end
         pli_pkg::ST_INS_CHECK: begin
            shift_pos_in = count_ff;
         end
         pli_pkg::ST_SHIFT_RD: begin
            rd_addr = AW'(shift_pos_ff - CW'(1));
         end
         pli_pkg::ST_SHIFT_WR: begin
            wr_en        = 1'b1;
            wr_addr      = AW'(shift_pos_ff);
            wr_data      = rd_data;
            shift_pos_in = shift_pos_ff - CW'(1);
         end
         pli_pkg::ST_WRITE: begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
         end
         pli_pkg::ST_Q_LATCH: begin
            x0_in = rd_x;
            y0_in = rd_y;
            up_in = $signed(y1_ff) >= $signed(rd_y);
         end
         pli_pkg::ST_DIV_GO: begin
            md_start = 1'b1;
         end
         pli_pkg::ST_DIV_WAIT: begin
            if (md_done) begin
               value_in = up_ff ? (y0_ff + md_q) : (y0_ff - md_q);
               inr_in   = 1'b1;
            end
         end
         pli_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               out_value_in = value_ff;
               out_inr_in   = inr_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pli_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      func_ff      <= func_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      x0_ff        <= x0_in;
      y0_ff        <= y0_in;
      x1_ff        <= x1_in;
      y1_ff        <= y1_in;
      up_ff        <= up_in;
      hit_ff       <= hit_in;
      value_ff     <= value_in;
      inr_ff       <= inr_in;
      out_value_ff <= out_value_in;
      out_inr_ff   <= out_inr_in;
      shift_pos_ff <= shift_pos_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = {out_value_ff, out_inr_ff};

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("point count above table depth");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == pli_pkg::ST_IDLE)
      else $error("request ready outside idle");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.data)))
      else $error("response item changed while stalled");
   a_rsp_in_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !out_inr_ff) |-> out_value_ff == '0)
      else $error("out of range response with nonzero value");
`endif
endmodule
`default_nettype wire
